[hw/rtl/spi_master_byte_shifter_top_assert.svh]
// Assertion macros for the SPI master byte shifter.
// Included by spi_master_byte_shifter_top; needs a clock and reset in scope.
`ifndef SPI_MASTER_BYTE_SHIFTER_TOP_ASSERT_SVH
`define SPI_MASTER_BYTE_SHIFTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMBS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smbs assertion failed");

// Next-cycle implication, checked outside reset.
`define SMBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smbs assertion failed");

`endif

[hw/rtl/smbs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and item types for the SPI master byte shifter.
// No dependencies.
package smbs_pkg;

   localparam int FRAME_BITS     = 8;
   localparam int DIVIDER_BITS   = 16;
   localparam int HALF_BITS      = 16;
   localparam int BYTE_BITS      = 8;
   localparam int TOTAL_EDGES    = 2 * FRAME_BITS;
   localparam int EDGE_BITS      = $clog2(TOTAL_EDGES + 1);
   localparam int LOAD_BITS      = (FRAME_BITS < BYTE_BITS) ? FRAME_BITS : BYTE_BITS;
   localparam int DIV_LOAD_BITS  = (DIVIDER_BITS < HALF_BITS) ? DIVIDER_BITS : HALF_BITS;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 16;

   typedef enum logic [1:0] {
      CMD_IDLE     = 2'd0,
      CMD_SEND     = 2'd1,
      CMD_SELECT   = 2'd2,
      CMD_DESELECT = 2'd3
   } cmd_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_POLARITY    = 2'd0,
      REG_PHASE       = 2'd1,
      REG_HALF_PERIOD = 2'd2
   } csr_reg_type;

   // One tick of input, lowest field in the lowest bits.
   typedef struct packed {
      logic                 miso_level;
      logic [BYTE_BITS-1:0] tx_byte;
      logic [1:0]           command;
   } req_item_type;

   // Pin levels and status after one tick, lowest field in the lowest bits.
   typedef struct packed {
      logic [BYTE_BITS-1:0] rx_byte;
      logic                 done_res;
      logic                 busy_res;
      logic                 nss_level;
      logic                 mosi;
      logic                 sclk;
   } rsp_item_type;

   localparam int REQ_ITEM_BITS = $bits(req_item_type);
   localparam int RSP_ITEM_BITS = $bits(rsp_item_type);

endpackage

[hw/rtl/smbs_in_stage.sv]
`timescale 1ns / 1ps
// Input register for the request stream of the SPI master byte shifter.
// Depends on smbs_pkg.
module smbs_in_stage
   import smbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     take,
   output logic                     item_valid,
   output req_item_type             item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   assign req_tready = !reset && (!valid_ff || take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         item_in  = req_item_type'(req_tdata[REQ_ITEM_BITS-1:0]);
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

[hw/rtl/smbs_core.sv]
`timescale 1ns / 1ps
// Shifter state, divider, edge counter and configuration registers.
// Advances by one tick per taken item. Depends on smbs_pkg.
module smbs_core
   import smbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     take,
   input  req_item_type             item,
   output rsp_item_type             result
);

   logic                    polarity_ff, polarity_in;
   logic                    phase_ff, phase_in;
   logic [HALF_BITS-1:0]    half_ff, half_in;

   logic [FRAME_BITS-1:0]   tx_ff, tx_in;
   logic [FRAME_BITS-1:0]   rx_ff, rx_in;
   logic [EDGE_BITS-1:0]    edge_ff, edge_in;
   logic [DIVIDER_BITS-1:0] div_ff, div_in;
   logic                    busy_ff, busy_in;
   logic                    clk_ff, clk_in;
   logic                    dout_ff, dout_in;
   logic                    sel_ff, sel_in;

   logic [DIVIDER_BITS-1:0] limit;
   logic [FRAME_BITS-1:0]   tx_frame;
   logic [EDGE_BITS-1:0]    edge_next;
   logic                    sample;
   logic                    done;
   logic [BYTE_BITS-1:0]    rx_out;

   always_comb begin
      limit = '0;
      limit[DIV_LOAD_BITS-1:0] = half_ff[DIV_LOAD_BITS-1:0];
      tx_frame = '0;
      tx_frame[LOAD_BITS-1:0] = item.tx_byte[LOAD_BITS-1:0];
   end

   // Configuration writes
   always_comb begin
      polarity_in = polarity_ff;
      phase_in    = phase_ff;
      half_in     = half_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_POLARITY:    polarity_in = csr_wdata[0];
            REG_PHASE:       phase_in    = csr_wdata[0];
            REG_HALF_PERIOD: half_in     = csr_wdata[HALF_BITS-1:0];
            default:         ;
         endcase
      end
   end

   // One tick of the shifter
   always_comb begin
      tx_in     = tx_ff;
      rx_in     = rx_ff;
      edge_in   = edge_ff;
      div_in    = div_ff;
      busy_in   = busy_ff;
      clk_in    = clk_ff;
      dout_in   = dout_ff;
      sel_in    = sel_ff;
      done      = 1'b0;
      rx_out    = '0;
      edge_next = edge_ff + EDGE_BITS'(1);
      sample    = phase_ff ? !edge_next[0] : edge_next[0];

      if (take) begin
         if (busy_ff) begin
            if (div_ff >= limit) begin
               div_in  = '0;
               clk_in  = !clk_ff;
               edge_in = edge_next;
               if (sample) begin
                  rx_in = {rx_ff[FRAME_BITS-2:0], item.miso_level};
               end else if (edge_next < EDGE_BITS'(TOTAL_EDGES)) begin
                  dout_in = tx_ff[FRAME_BITS-1];
                  tx_in   = {tx_ff[FRAME_BITS-2:0], 1'b0};
               end
               if (edge_next >= EDGE_BITS'(TOTAL_EDGES)) begin
                  busy_in = 1'b0;
                  done    = 1'b1;
                  rx_out[LOAD_BITS-1:0] = rx_in[LOAD_BITS-1:0];
                  clk_in  = polarity_ff;
                  edge_in = '0;
               end
            end else begin
               div_in = div_ff + DIVIDER_BITS'(1);
            end
         end else begin
            case (item.command)
               CMD_SEND: begin
                  tx_in   = tx_frame;
                  rx_in   = '0;
                  edge_in = '0;
                  div_in  = '0;
                  busy_in = 1'b1;
                  clk_in  = polarity_ff;
                  // mode with phase 0 launches the first bit at start
                  if (!phase_ff) begin
                     dout_in = tx_frame[FRAME_BITS-1];
                     tx_in   = {tx_frame[FRAME_BITS-2:0], 1'b0};
                  end
               end
               CMD_SELECT:   sel_in = 1'b0;
               CMD_DESELECT: sel_in = 1'b1;
               default:      ;
            endcase
         end
      end else if (csr_we && csr_addr == REG_POLARITY && !busy_ff) begin
         // idle clock follows the new polarity at once
         clk_in = csr_wdata[0];
      end
   end

   assign result.sclk      = clk_in;
   assign result.mosi      = dout_in;
   assign result.nss_level = sel_in;
   assign result.busy_res  = busy_in;
   assign result.done_res  = done;
   assign result.rx_byte   = rx_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= 1'b0;
         phase_ff    <= 1'b0;
         half_ff     <= '0;
         tx_ff       <= '0;
         rx_ff       <= '0;
         edge_ff     <= '0;
         div_ff      <= '0;
         busy_ff     <= 1'b0;
         clk_ff      <= 1'b0;
         dout_ff     <= 1'b0;
         sel_ff      <= 1'b1;
      end else begin
         polarity_ff <= polarity_in;
         phase_ff    <= phase_in;
         half_ff     <= half_in;
         tx_ff       <= tx_in;
         rx_ff       <= rx_in;
         edge_ff     <= edge_in;
         div_ff      <= div_in;
         busy_ff     <= busy_in;
         clk_ff      <= clk_in;
         dout_ff     <= dout_in;
         sel_ff      <= sel_in;
      end
   end

endmodule

[hw/rtl/smbs_out_stage.sv]
`timescale 1ns / 1ps
// Result register for the response stream of the SPI master byte shifter.
// Depends on smbs_pkg.
module smbs_out_stage
   import smbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  rsp_item_type             result,
   output logic                     space,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff, data_in;

   assign space      = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(data_ff);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

[hw/rtl/spi_master_byte_shifter_top.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Handshake          | Payload
// req_     | in  | tvalid/tready      | one tick: command, tx_byte, miso_level
// rsp_     | out | tvalid/tready      | pin levels and status after the tick
// csr_     | in  | we, one cycle      | clock_polarity, clock_phase, half_period
//
// One tick accepted per cycle while rsp_ does not stall; each result passes
// through the input register, then the result register, with the shifter
// step between.
// Reset is synchronous, active high; req_tready is low while reset is high.
// A stalled rsp_ side holds the result and backs up into the input register.
// Top level of the SPI master byte shifter. Depends on smbs_pkg, smbs_in_stage,
// smbs_core, smbs_out_stage and spi_master_byte_shifter_top_assert.svh.
`include "spi_master_byte_shifter_top_assert.svh"

module spi_master_byte_shifter_top
   import smbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [1:0] command, [9:2] tx_byte, [10] miso_level, rest zero
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] sclk, [1] mosi, [2] nss_level, [3] busy_res, [4] done_res,
   // [12:5] rx_byte, rest zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         space;
   logic         take;

   // advance one tick when the result register can take it
   assign take = item_valid && space;

   smbs_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   smbs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .take      (take),
      .item      (item),
      .result    (result)
   );

   smbs_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `SMBS_ASSERT_NEXT(a_take_loads_result, take, rsp_tvalid)
   `SMBS_ASSERT_NOW(a_done_ends_busy, take && result.done_res, !result.busy_res)
   `SMBS_ASSERT_NOW(a_rx_only_on_done, take && !result.done_res, result.rx_byte == '0)

endmodule
